>>> src/fahf_pkg.sv
// shared types and constants for the frame accumulator hit finder
// no dependencies

package fahf_pkg;

    localparam int MAX_PIXELS = 65536;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 16;
    localparam int FRAME_W = 16;
    localparam int SIZE_W  = 17;
    localparam int THR_W   = 16;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 2;
    localparam int DIN_W   = 8;
    localparam int DOUT_W  = 56;

    localparam logic [IDX_W-1:0] REG_FRAME_PIXELS = 2'd0;
    localparam logic [IDX_W-1:0] REG_HIT_THRESH   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_LIMIT  = 2'd2;

    localparam logic [PIX_W-1:0] CLAMP_MAX = 8'd255;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN
    } ctl_state_t;

    typedef struct packed {
        logic [POS_W-1:0]   pixel_position;
        logic [FRAME_W-1:0] frame_number;
        logic               readout_valid;
        logic               end_of_frame;
        logic               frame_hit;
    } pix_tag_t;

endpackage

>>> src/frame_accumulator_hit_finder.sv
// frame accumulator hit finder top level: sum memory, control and output stage
// depends on fahf_pkg and fahf_divider
// each pixel steps through read, modify and present; with readout it also waits on the
// serial divider between modify and present. one pixel is in flight at a time and the
// input is taken only when idle, so no new pixel is taken until the result has gone on m_tready.
// after reset a clearing pass zeroes the sum memory; no pixel is taken during it,
// configuration writes are.

module frame_accumulator_hit_finder #(
    parameter int SUM_BITS   = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fahf_pkg::IDX_W-1:0]    cfg_index,
    input  logic [fahf_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fahf_pkg::DIN_W-1:0]    s_tdata,  // pixel_value
    input  logic                          s_tuser,  // readout_request
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_position, frame_number, readout_valid, clamped_sum, average_value
    output logic [fahf_pkg::DOUT_W-1:0]   m_tdata,
    output logic                          m_tlast,  // end_of_frame
    output logic                          m_tuser   // frame_hit
);
    import fahf_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int MSZ_W  = $clog2(MAX_PIXELS + 1);
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
    localparam int FT_W   = 25;
    localparam int PROD_W = 34;

    typedef enum logic [2:0] {
        P_IDLE,
        P_READ,
        P_MOD,
        P_DIV,
        P_OUT
    } pipe_state_t;

    logic [SUM_BITS-1:0] mem [MAX_PIXELS];
    logic [SUM_BITS-1:0] rd_data_reg;

    logic [SIZE_W-1:0] frame_pixels_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [FRAME_W-1:0] limit_reg;

    ctl_state_t  ctl_reg, ctl_next;
    pipe_state_t ps_reg, ps_next;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [ADDR_W-1:0] pos_reg;
    logic [FRAME_W-1:0] frames_reg;
    logic               latch_reg;
    logic [FT_W-1:0]    ftotal_reg;

    logic [PIX_W-1:0]  pix_reg;
    logic [PROD_W-1:0] lhs_reg, rhs_reg;
    pix_tag_t          tag_reg;
    logic [PIX_W-1:0]  csum_reg, avg_reg;

    logic [MSZ_W-1:0]  size;
    logic              accept;
    logic [ADDR_W-1:0] cur_pos;
    logic              cur_latch;
    logic [SUM_BITS:0] sum_add;
    logic [SUM_BITS-1:0] new_sum;
    logic [FT_W-1:0]   new_ftotal;
    logic              last;
    logic              out_take;
    logic              div_busy, div_done;
    logic [PIX_W-1:0]  div_q;

    always_comb begin
        if (frame_pixels_reg == '0 || frame_pixels_reg > SIZE_W'(MAX_PIXELS)) begin
            size = MSZ_W'(MAX_PIXELS);
        end else begin
            size = MSZ_W'(frame_pixels_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= SIZE_W'(65536);
            thr_reg          <= '0;
            limit_reg        <= FRAME_W'(65535);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_PIXELS: frame_pixels_reg <= cfg_data[SIZE_W-1:0];
                REG_HIT_THRESH:   thr_reg          <= cfg_data[THR_W-1:0];
                REG_FRAME_LIMIT:  limit_reg        <= cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // clear control
    always_comb begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            ST_CLEAR: if (clr_addr_reg == ADDR_W'(MAX_PIXELS - 1)) ctl_next = ST_RUN;
            ST_RUN:   ctl_next = ST_RUN;
            default:  ctl_next = ST_CLEAR;
        endcase
    end

    assign s_tready = (ctl_reg == ST_RUN) && (ps_reg == P_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    // pixel pipeline sequencing
    always_comb begin
        ps_next = ps_reg;
        unique case (ps_reg)
            P_IDLE: if (accept && frames_reg < limit_reg) ps_next = P_READ;
            P_READ: ps_next = P_MOD;
            P_MOD:  ps_next = tag_reg.readout_valid ? P_DIV : P_OUT;
            P_DIV:  if (div_done) ps_next = P_OUT;
            P_OUT:  if (out_take) ps_next = P_IDLE;
            default: ps_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg      <= ST_CLEAR;
            ps_reg       <= P_IDLE;
            clr_addr_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
            ps_reg  <= ps_next;
            if (ctl_reg == ST_CLEAR) clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign cur_pos   = pos_reg;
    assign cur_latch = (pos_reg == '0) ? s_tuser : latch_reg;

    assign sum_add    = {1'b0, rd_data_reg} + (SUM_BITS + 1)'(pix_reg);
    assign new_sum    = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
    assign new_ftotal = ftotal_reg + FT_W'(pix_reg);
    assign last       = (MSZ_W'(pos_reg) + MSZ_W'(1)) >= size;

    // memory: clear writes, read of the current position every cycle, write back in modify
    always_ff @(posedge aclk) begin
        if (ctl_reg == ST_CLEAR) begin
            mem[clr_addr_reg] <= '0;
        end else if (ps_reg == P_MOD) begin
            mem[tag_reg.pixel_position[ADDR_W-1:0]] <= new_sum;
        end
        rd_data_reg <= mem[cur_pos];
    end

    // item state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            frames_reg <= '0;
            latch_reg  <= 1'b0;
            ftotal_reg <= '0;
        end else if (ps_reg == P_IDLE && ps_next == P_READ) begin
            latch_reg <= cur_latch;
            pix_reg   <= s_tdata[PIX_W-1:0];
            tag_reg.pixel_position <= POS_W'(pos_reg);
            tag_reg.frame_number   <= frames_reg;
            tag_reg.readout_valid  <= cur_latch;
        end else if (ps_reg == P_READ) begin
            tag_reg.end_of_frame <= last;
            if (last) begin
                pos_reg    <= '0;
                frames_reg <= frames_reg + FRAME_W'(1);
                latch_reg  <= 1'b0;
                ftotal_reg <= '0;
            end else begin
                pos_reg    <= pos_reg + ADDR_W'(1);
                ftotal_reg <= new_ftotal;
            end
            lhs_reg <= {1'b0, new_ftotal, 8'd0};
            rhs_reg <= PROD_W'(thr_reg) * PROD_W'(size);
        end else if (ps_reg == P_MOD) begin
            tag_reg.frame_hit <= tag_reg.end_of_frame && (lhs_reg > rhs_reg);
            csum_reg <= (new_sum > SUM_BITS'(CLAMP_MAX)) ? CLAMP_MAX : new_sum[PIX_W-1:0];
        end
    end

    fahf_divider #(.SUM_BITS(SUM_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ps_reg == P_MOD && tag_reg.readout_valid),
        .dividend (new_sum),
        .divisor  ({1'b0, tag_reg.frame_number} + 17'd1),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (div_done && !div_busy) avg_reg <= div_q;
    end

    assign m_tvalid = (ps_reg == P_OUT);
    assign m_tdata  = {7'd0,
                       tag_reg.readout_valid ? avg_reg : 8'd0,
                       tag_reg.readout_valid ? csum_reg : 8'd0,
                       tag_reg.readout_valid,
                       tag_reg.frame_number, tag_reg.pixel_position};
    assign m_tlast  = tag_reg.end_of_frame;
    assign m_tuser  = tag_reg.frame_hit;

endmodule

>>> src/fahf_divider.sv
// restoring divider, one quotient bit per cycle, saturates quotient at 255
// depends on fahf_pkg

module fahf_divider #(
    parameter int SUM_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [SUM_BITS-1:0]     dividend,
    input  logic [fahf_pkg::FRAME_W:0] divisor,
    output logic                    busy,
    output logic                    done,
    output logic [fahf_pkg::PIX_W-1:0] quotient
);
    import fahf_pkg::*;

    localparam int CNT_W = $clog2(SUM_BITS + 1);
    localparam int REM_W = FRAME_W + 2;

    logic [SUM_BITS-1:0] quo_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [FRAME_W:0]    den_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    rem_sub;

    always_comb begin
        rem_shift = {rem_reg[REM_W-2:0], quo_reg[SUM_BITS-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_BITS);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                if (!rem_sub[REM_W-1]) begin
                    rem_reg <= rem_sub;
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = (quo_reg > SUM_BITS'(CLAMP_MAX)) ? CLAMP_MAX : quo_reg[PIX_W-1:0];

endmodule

>>> dv/tb.sv
// self-checking bench for frame_accumulator_hit_finder: directed table and frame-limit cases, then random pixels
// predicts per-pixel sums, averages and frame hits; depends on fahf_pkg and the rtl

module tb;
    import fahf_pkg::*;

    typedef struct packed {
        logic [7:0]  average_value;
        logic [7:0]  clamped_sum;
        logic        readout_valid;
        logic [15:0] frame_number;
        logic [15:0] pixel_position;
        logic        end_of_frame;
        logic        frame_hit;
    } pix_result_t;

    typedef struct {
        logic [7:0]  pix;
        logic        req;
        logic        chk;
        pix_result_t res;
    } stim_row_t;

    localparam int NMAX = 65536;
    localparam longint SUM_SAT = (64'd1 << 24) - 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DIN_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DOUT_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    frame_accumulator_hit_finder i_dut (.*);

    longint pixel_acc [NMAX];
    longint frame_acc;
    int unsigned pos_cnt, frames_seen;
    bit latch_rd;
    int unsigned size_reg, thr_reg, limit_reg;

    pix_result_t pending_q[$];
    int errors = 0, checked = 0, hits_seen = 0, reads_seen = 0;
    int send_idle = 34, recv_idle = 64;
    bit hold_recv = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #200000000;
        $display("FAIL frame_accumulator_hit_finder");
        $finish;
    end

    function automatic bit predict_pixel(input logic [7:0] pix, input logic req,
                                         output pix_result_t r);
        int unsigned sz, p;
        longint s, avg;
        bit lst;
        sz = (size_reg == 0 || size_reg > NMAX) ? NMAX : size_reg;
        p = pos_cnt;
        r = '0;
        if (frames_seen >= limit_reg) return 1'b0;
        if (p >= NMAX) p = NMAX - 1;
        if (p == 0) latch_rd = req;
        s = pixel_acc[p] + pix;
        if (s > SUM_SAT) s = SUM_SAT;
        pixel_acc[p] = s;
        frame_acc += pix;
        lst = (p + 1 >= sz);
        r.pixel_position = p[15:0];
        r.frame_number = frames_seen[15:0];
        r.readout_valid = latch_rd;
        if (latch_rd) begin
            avg = s / (longint'(frames_seen) + 1);
            r.clamped_sum = (s > 255) ? 8'd255 : s[7:0];
            r.average_value = (avg > 255) ? 8'd255 : avg[7:0];
        end
        r.end_of_frame = lst;
        if (lst) r.frame_hit = (frame_acc * 256) > (longint'(thr_reg) * sz);
        if (lst) begin
            pos_cnt = 0;
            frame_acc = 0;
            frames_seen = (frames_seen + 1) & 16'hffff;
            latch_rd = 1'b0;
        end else begin
            pos_cnt = p + 1;
        end
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_PIXELS: size_reg = val & 32'h1ffff;
            REG_HIT_THRESH:   thr_reg = val & 32'hffff;
            default:          limit_reg = val & 32'hffff;
        endcase
    endtask

    // request channel: offer one pixel, wait for handshake, predict on accept
    task automatic send_pixel(input logic [7:0] pix, input logic req,
                              input logic chk, input pix_result_t want);
        pix_result_t r;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= req;
        do @(posedge aclk); while (!s_tready);
        if (predict_pixel(pix, req, r)) begin
            if (chk && r !== want) begin
                errors++;
                if (errors <= 10)
                    $display("table row mismatch: predicted %h, typed %h", r, want);
            end
            pending_q.push_back(r);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain(input int extra);
        int guard;
        guard = 0;
        while (pending_q.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (extra) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_recv) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        pix_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pixel_position = m_tdata[15:0];
            got.frame_number = m_tdata[31:16];
            got.readout_valid = m_tdata[32];
            got.clamped_sum = m_tdata[40:33];
            got.average_value = m_tdata[48:41];
            got.end_of_frame = m_tlast;
            got.frame_hit = m_tuser;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_q.pop_front();
                checked++;
                if (got.frame_hit) hits_seen++;
                if (got.readout_valid) reads_seen++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %h, got %h", want, got);
                end
            end
        end
    end

    stim_row_t dir_rows[$];

    function automatic stim_row_t row(input logic [7:0] p, input logic q, input logic c,
                                      input pix_result_t r);
        stim_row_t t;
        t.pix = p;
        t.req = q;
        t.chk = c;
        t.res = r;
        return t;
    endfunction

    function automatic pix_result_t mk(input int pos, input int fr, input bit rv,
                                       input int cs, input int av, input bit eof, input bit hit);
        pix_result_t r;
        r.pixel_position = 16'(pos);
        r.frame_number = 16'(fr);
        r.readout_valid = rv;
        r.clamped_sum = 8'(cs);
        r.average_value = 8'(av);
        r.end_of_frame = eof;
        r.frame_hit = hit;
        return r;
    endfunction

    initial begin
        int unsigned sz;
        int n;
        foreach (pixel_acc[i]) pixel_acc[i] = 0;
        frame_acc = 0;
        pos_cnt = 0;
        frames_seen = 0;
        latch_rd = 0;
        size_reg = 65536;
        thr_reg = 0;
        limit_reg = 65535;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // frames of 3 pixels, threshold mean 100
        write_reg(REG_FRAME_PIXELS, 3);
        write_reg(REG_HIT_THRESH, 100 * 256);
        write_reg(REG_FRAME_LIMIT, 65535);
        dir_rows.push_back(row(8'd0, 1'b1, 1'b1, mk(0, 0, 1, 0, 0, 0, 0)));
        dir_rows.push_back(row(8'd255, 1'b0, 1'b1, mk(1, 0, 1, 255, 255, 0, 0)));
        dir_rows.push_back(row(8'd255, 1'b0, 1'b1, mk(2, 0, 1, 255, 255, 1, 1)));
        dir_rows.push_back(row(8'd255, 1'b0, 1'b1, mk(0, 1, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(8'd0, 1'b1, 1'b1, mk(1, 1, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(8'd45, 1'b0, 1'b1, mk(2, 1, 0, 0, 0, 1, 0)));
        dir_rows.push_back(row(8'd1, 1'b1, 1'b0, '0));
        dir_rows.push_back(row(8'd128, 1'b1, 1'b0, '0));
        dir_rows.push_back(row(8'd170, 1'b0, 1'b0, '0));
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].pix, dir_rows[i].req, dir_rows[i].chk, dir_rows[i].res);
        drain(40);

        // single-pixel frames, top threshold, then frame limit drops
        write_reg(REG_FRAME_PIXELS, 1);
        write_reg(REG_HIT_THRESH, 65535);
        for (int i = 0; i < 6; i++)
            send_pixel(8'(i * 51), i[0], 1'b0, '0);
        drain(40);
        write_reg(REG_FRAME_LIMIT, frames_seen + 2);
        for (int i = 0; i < 5; i++) send_pixel(8'hff, 1'b1, 1'b0, '0);
        drain(40);
        write_reg(REG_FRAME_LIMIT, 0);
        send_pixel(8'h5a, 1'b1, 1'b0, '0);
        drain(40);
        write_reg(REG_FRAME_LIMIT, 65535);
        write_reg(REG_HIT_THRESH, 0);

        // random phases with varying frame sizes and thresholds
        n = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 34 : (ph == 1) ? 64 : 0;
            recv_idle = (ph == 0) ? 64 : (ph == 1) ? 34 : 0;
            for (int blk = 0; blk < 10; blk++) begin
                sz = $urandom_range(1, 12);
                if (blk == 9) sz = 0;
                write_reg(REG_FRAME_PIXELS, (sz == 0) ? 32'h1ffff : sz);
                write_reg(REG_HIT_THRESH, $urandom_range(0, 2) == 0 ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 255 * 256));
                if (blk == 3) begin
                    fork
                        begin
                            hold_recv = 1'b1;
                            repeat (300) @(negedge aclk);
                            hold_recv = 1'b0;
                        end
                    join_none
                end
                for (int i = 0; i < 65; i++) begin
                    send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                               1'b0, '0);
                    n++;
                end
                drain(60);
            end
        end

        drain(60);
        $display("covered %0d pixels (%0d random), %0d results checked, %0d hits, %0d readouts",
                 n + 21, n, checked, hits_seen, reads_seen);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("PASS frame_accumulator_hit_finder");
        end else begin
            $display("FAIL frame_accumulator_hit_finder");
        end
        $finish;
    end
endmodule
